// ===== src/srg_pkg.sv =====
// Shared types, constants and the modulus reduction for the seeded LCG row generator.
// Used by srg_ctrl, srg_dp and seeded_lcg_row_generator. No other dependencies.
`timescale 1ns / 1ps
`default_nettype none
package srg_pkg;

	// Generator constants. The multiplier is 2^31 - 19, so a product is a shift minus 19*s.
	localparam logic [31:0] LCG_M     = 32'd2147483647;
	localparam logic [31:0] LCG_C     = 32'd2147483587;
	localparam logic [31:0] LCG_A_NEG = 32'd19;

	// Configuration register indexes.
	localparam logic [1:0] REG_PRIMARY_SEED    = 2'd0;
	localparam logic [1:0] REG_OP_SEED         = 2'd1;
	localparam logic [1:0] REG_SEED_OFFSET     = 2'd2;
	localparam logic [1:0] REG_VALUES_PER_SEED = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // take a request and compute the row's start state
		logic step;   // advance the generator and fill the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;  // the current row length is zero
		logic left_last;   // exactly one value of the row is still owed
		logic out_free;    // the output register can take a value this cycle
	} status_t;

	// Reduce a 32-bit value modulo 2^31-1: fold bit 31 in, then one conditional subtract.
	function automatic logic [30:0] mod_m(input logic [31:0] x);
		logic [31:0] folded;
		folded = {1'b0, x[30:0]} + {31'd0, x[31]};
		if (folded >= LCG_M) begin
			folded = folded - LCG_M;
		end
		return folded[30:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/seeded_lcg_row_generator.sv =====
// Seeded LCG row generator, top level. A request is taken in the idle cycle, the start
// state is formed at that edge, and the first value reaches the output register with the
// first step after it. A row then yields one value per cycle while the consumer keeps up;
// an empty row yields no value and leaves the block idle. The step loop through the
// generator state sets that rate. Reset clears the generator state and row counter and
// restores the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module seeded_lcg_row_generator #(
	parameter int MAX_VALUES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] row_seed,
	input  wire logic [30:0] alt_seed,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [30:0]      rand_value,
	output logic             row_last
);

	srg_pkg::cmd_t    cmd;
	srg_pkg::status_t status;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	srg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	srg_dp #(
		.MAX_VALUES (MAX_VALUES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_write  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.row_seed   (row_seed),
		.alt_seed   (alt_seed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rand_value (rand_value),
		.row_last   (row_last)
	);

	// A generator value is always reduced below the modulus.
	a_value_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rand_value != 31'h7FFFFFFF))
		else $error("rand_value not reduced below the modulus");

	// The controller never loads and steps in the same cycle.
	a_load_step_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step issued together");

	// A step never overwrites a value the consumer has not taken.
	a_step_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!out_valid || out_ready))
		else $error("step would overwrite a pending value");

	// After a step that ends the row, the block is ready for a new request.
	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.left_last) |=> (in_ready && out_valid && row_last))
		else $error("row end did not return to idle with a flagged value");

endmodule
`default_nettype wire

// ===== src/srg_ctrl.sv =====
// Controller state machine of the seeded LCG row generator.
// Depends on srg_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module srg_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire srg_pkg::status_t status,
	output srg_pkg::cmd_t        cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;

	// A request is taken only while no row is in progress.
	assign in_ready = (state_q == ST_IDLE);
	assign cmd.load = in_valid && (state_q == ST_IDLE);
	assign cmd.step = (state_q == ST_RUN) && status.out_free;

	// Row sequencing: enter RUN for a nonempty row, leave after its last value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load && !status.count_zero) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.step && status.left_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/srg_dp.sv =====
// Datapath of the seeded LCG row generator: configuration registers, seed selection,
// generator state, row counter and output register. Depends on srg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srg_dp #(
	parameter int MAX_VALUES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire srg_pkg::cmd_t    cmd,
	output srg_pkg::status_t      status,
	input  wire logic             cfg_write,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [31:0]      cfg_data,
	input  wire logic [31:0]      row_seed,
	input  wire logic [30:0]      alt_seed,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [30:0]           rand_value,
	output logic                  row_last
);

	localparam int CW = $clog2(MAX_VALUES + 1);

	logic [31:0]   primary_seed_q;
	logic [31:0]   op_seed_q;
	logic [31:0]   seed_offset_q;
	logic [6:0]    values_per_seed_q;
	logic [30:0]   lcg_state_q;
	logic [CW-1:0] values_left_q;
	logic          out_valid_q;
	logic [30:0]   rand_value_q;
	logic          row_last_q;

	logic [CW-1:0] row_count;
	logic [31:0]   seed;
	logic [30:0]   start_state;
	logic [31:0]   state_ext;
	logic [31:0]   times_neg;
	logic [31:0]   step_sum;
	logic [30:0]   next_state;

	// Configuration registers; an index beyond the list changes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_seed_q    <= '0;
			op_seed_q         <= '0;
			seed_offset_q     <= '0;
			values_per_seed_q <= 7'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				srg_pkg::REG_PRIMARY_SEED:    primary_seed_q    <= cfg_data;
				srg_pkg::REG_OP_SEED:         op_seed_q         <= cfg_data;
				srg_pkg::REG_SEED_OFFSET:     seed_offset_q     <= cfg_data;
				srg_pkg::REG_VALUES_PER_SEED: values_per_seed_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Row length, saturated to the configured bound.
	always_comb begin
		if (values_per_seed_q > 7'(MAX_VALUES)) begin
			row_count = CW'(MAX_VALUES);
		end else begin
			row_count = CW'(values_per_seed_q);
		end
	end

	// Seed fallback chain, then offset with a 32-bit wrap and reduction.
	always_comb begin
		if (row_seed != '0) begin
			seed = row_seed;
		end else if (primary_seed_q != '0) begin
			seed = primary_seed_q;
		end else if (op_seed_q != '0) begin
			seed = op_seed_q;
		end else begin
			seed = {1'b0, alt_seed};
		end
		start_state = srg_pkg::mod_m(seed + seed_offset_q);
	end

	// One generator step: A*s mod 2^32 equals (s << 31) - 19*s, then add C and reduce.
	always_comb begin
		state_ext  = {1'b0, lcg_state_q};
		times_neg  = (state_ext << 4) + (state_ext << 1) + state_ext;
		step_sum   = {lcg_state_q[0], 31'd0} + srg_pkg::LCG_C - times_neg;
		next_state = srg_pkg::mod_m(step_sum);
	end

	// Generator state and the count of values still owed for the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_state_q   <= '0;
			values_left_q <= '0;
		end else if (cmd.load) begin
			lcg_state_q   <= start_state;
			values_left_q <= row_count;
		end else if (cmd.step) begin
			lcg_state_q   <= next_state;
			values_left_q <= values_left_q - CW'(1);
		end
	end

	// Output register: filled on a step, emptied when the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rand_value_q <= next_state;
			row_last_q   <= (values_left_q == CW'(1));
		end
	end

	assign status.count_zero = (row_count == '0);
	assign status.left_last  = (values_left_q == CW'(1));
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign rand_value = rand_value_q;
	assign row_last   = row_last_q;

endmodule
`default_nettype wire
